// File: sv/atl_pkg.sv
// Shared types, token codes and keyword tables for the assembly token lexer.
`timescale 1ns / 1ps

package atl_pkg;

  // Token kinds
  localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
  localparam logic [2:0] KIND_INSTR    = 3'd1;
  localparam logic [2:0] KIND_REGISTER = 3'd2;
  localparam logic [2:0] KIND_IMMED    = 3'd3;
  localparam logic [2:0] KIND_COMMA    = 3'd4;
  localparam logic [2:0] KIND_NEWLINE  = 3'd5;
  localparam logic [2:0] KIND_LABEL    = 3'd6;

  // Scanner modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_WORD   = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  localparam int unsigned NUM_KEYWORDS = 10;
  localparam int unsigned KEY_CHARS    = 4;

  // Mnemonics, packed right-aligned, and their lengths
  localparam logic [31:0] MNEM_TEXT [NUM_KEYWORDS] = '{
    32'h004D4F56, 32'h00414444, 32'h004D5649, 32'h00414E44, 32'h00414E49,
    32'h00584F52, 32'h00535542, 32'h00494E52, 32'h00444352, 32'h004A4E5A
  };
  localparam logic [2:0] MNEM_LEN [NUM_KEYWORDS] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
  };

  // Register names
  localparam logic [31:0] REG_TEXT [NUM_KEYWORDS] = '{
    32'h00000041, 32'h00000042, 32'h00000043, 32'h00000044, 32'h00000045,
    32'h00000048, 32'h0000004C, 32'h00005350, 32'h00005043, 32'h464C4147
  };
  localparam logic [2:0] REG_LEN [NUM_KEYWORDS] = '{
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4
  };

  // Output queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  code;
    logic [15:0] value;
    logic        overflow;
    logic [15:0] start;
    logic [7:0]  length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] code;
  } match_t;

  // Classify a finished word of up to four characters; mnemonics win over
  // registers, and the lowest table index wins within a table.
  function automatic match_t keyword_match(input logic [31:0] text,
                                           input logic [2:0] len);
    match_t m;
    m.kind = KIND_UNKNOWN;
    m.code = 4'd0;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      if (REG_LEN[i] == len && REG_TEXT[i] == text) begin
        m.kind = KIND_REGISTER;
        m.code = 4'(i);
      end
    end
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      if (MNEM_LEN[i] == len && MNEM_TEXT[i] == text) begin
        m.kind = KIND_INSTR;
        m.code = 4'(i);
      end
    end
    return m;
  endfunction

endpackage

// File: sv/assembly_token_lexer_top.sv
// Top level of the assembly token lexer: scanner state and output token queue.
`timescale 1ns / 1ps

// Assembly token lexer. Source text enters one byte per beat on char_code;
// a beat with end_of_text set carries no byte and flushes the pending word
// or number, then restarts the offset count at zero for the next text.
// Each byte is classified and the scanner state updated in the cycle it is
// accepted, so the input side takes one byte per clock. A token is written
// to the queue when the beat that completes it is accepted. A byte yields
// zero, one or two tokens (a run that ends plus a comma or newline token);
// the tokens go into a four-entry queue and leave one per beat, with last
// set on the final token of each input beat. The input stalls while fewer
// than two queue entries are free, so the sustained rate is one byte per
// clock unless the output side stalls or the text is dense in commas and
// newlines that end runs. Words that hold a colon are labels; otherwise
// an exact, case-sensitive match against the mnemonic and register tables
// gives an instruction or register with its table index, else unknown.
// Digit runs give immediates whose value saturates at 65535 with
// number_overflow set. Offsets count modulo 2^OFFSET_BITS and show in the
// low 16 bits; lengths saturate at MAX_TOKEN_LENGTH.
module assembly_token_lexer_top #(
  parameter int unsigned OFFSET_BITS      = 16,
  parameter int unsigned MAX_TOKEN_LENGTH = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [3:0]  keyword_code,
  output logic [15:0] number_value,
  output logic        number_overflow,
  output logic [15:0] start_offset,
  output logic [7:0]  token_length,
  output logic        last
);

  // Run length counts one past the maximum so that saturation stays exact
  localparam int unsigned RL_W = $clog2(MAX_TOKEN_LENGTH + 2);
  localparam logic [RL_W-1:0] RL_CAP  = RL_W'(MAX_TOKEN_LENGTH + 1);
  localparam logic [RL_W-1:0] RL_SHOW = RL_W'(MAX_TOKEN_LENGTH);
  localparam logic [RL_W-1:0] RL_KEY  = RL_W'(atl_pkg::KEY_CHARS);

  // Scanner state
  logic [1:0]             scan_mode, scan_mode_next;
  logic [RL_W-1:0]        run_length, run_length_next;
  logic [31:0]            leading_chars, leading_chars_next;
  logic                   colon_seen, colon_seen_next;
  logic [15:0]            number_accumulator, number_accumulator_next;
  logic                   accumulator_saturated, accumulator_saturated_next;
  logic [OFFSET_BITS-1:0] run_start, run_start_next;
  logic [OFFSET_BITS-1:0] text_position, text_position_next;

  // Output queue
  atl_pkg::token_t                queue [atl_pkg::QUEUE_DEPTH];
  logic [atl_pkg::QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [atl_pkg::QUEUE_CW-1:0]   count;

  logic in_fire, out_fire;
  logic is_alpha, is_digit, is_colon, is_word_char, is_punct;
  logic flush, consumed;
  logic [1:0] push_n;
  logic [19:0] acc_times_ten;
  logic [RL_W-1:0] shown_len;
  atl_pkg::match_t match;
  atl_pkg::token_t run_tok, punct_tok, tok0, tok1;

  assign in_stall = count > atl_pkg::QUEUE_CW'(atl_pkg::QUEUE_DEPTH - 2);
  assign in_fire  = in_valid && !in_stall;
  assign out_valid = count != '0;
  assign out_fire  = out_valid && !out_stall;

  // Character classes: ASCII letters, digits and the colon only
  assign is_alpha = (char_code >= 8'h41 && char_code <= 8'h5A) ||
                    (char_code >= 8'h61 && char_code <= 8'h7A);
  assign is_digit = char_code >= 8'h30 && char_code <= 8'h39;
  assign is_colon = char_code == atl_pkg::CH_COLON;
  assign is_word_char = is_alpha || is_digit || is_colon;

  // Token for the run in progress, as it would be flushed now
  assign shown_len = (run_length > RL_SHOW) ? RL_SHOW : run_length;
  assign match = atl_pkg::keyword_match(leading_chars, run_length[2:0]);

  always_comb begin
    run_tok          = '0;
    run_tok.start    = 16'(run_start);
    run_tok.length   = 8'(shown_len);
    if (scan_mode == atl_pkg::MODE_NUMBER) begin
      run_tok.kind     = atl_pkg::KIND_IMMED;
      run_tok.value    = number_accumulator;
      run_tok.overflow = accumulator_saturated;
    end else if (colon_seen) begin
      run_tok.kind = atl_pkg::KIND_LABEL;
    end else if (run_length <= RL_KEY) begin
      run_tok.kind = match.kind;
      run_tok.code = match.code;
    end else begin
      run_tok.kind = atl_pkg::KIND_UNKNOWN;
    end
  end

  // Decide what this beat ends, consumes and emits
  always_comb begin
    consumed = 1'b0;
    flush    = 1'b0;
    if (end_of_text) begin
      flush = scan_mode != atl_pkg::MODE_IDLE;
    end else if (scan_mode == atl_pkg::MODE_WORD) begin
      consumed = is_word_char;
      flush    = !is_word_char;
    end else if (scan_mode == atl_pkg::MODE_NUMBER) begin
      consumed = is_digit;
      flush    = !is_digit;
    end
  end

  assign is_punct = !end_of_text && !consumed &&
                    (char_code == atl_pkg::CH_COMMA || char_code == atl_pkg::CH_NEWLINE);

  always_comb begin
    punct_tok        = '0;
    punct_tok.kind   = (char_code == atl_pkg::CH_COMMA) ? atl_pkg::KIND_COMMA
                                                        : atl_pkg::KIND_NEWLINE;
    punct_tok.start  = 16'(text_position);
    punct_tok.length = 8'd1;

    tok0 = flush ? run_tok : punct_tok;
    tok0.last = !(flush && is_punct);
    tok1 = punct_tok;
    tok1.last = 1'b1;
    push_n = 2'(flush) + 2'(is_punct);
  end

  // Next scanner state for an accepted beat
  assign acc_times_ten = {1'b0, number_accumulator, 3'b000} + {3'b000, number_accumulator, 1'b0};

  always_comb begin
    logic [19:0] acc_sum;
    acc_sum = acc_times_ten + 20'(char_code - atl_pkg::CH_ZERO);

    scan_mode_next             = scan_mode;
    run_length_next            = run_length;
    leading_chars_next         = leading_chars;
    colon_seen_next            = colon_seen;
    number_accumulator_next    = number_accumulator;
    accumulator_saturated_next = accumulator_saturated;
    run_start_next             = run_start;
    text_position_next         = text_position + OFFSET_BITS'(1);

    if (end_of_text) begin
      scan_mode_next     = atl_pkg::MODE_IDLE;
      text_position_next = '0;
    end else if (consumed) begin
      if (run_length < RL_CAP) begin
        run_length_next = run_length + RL_W'(1);
      end
      if (scan_mode == atl_pkg::MODE_WORD) begin
        if (run_length < RL_KEY) begin
          leading_chars_next = {leading_chars[23:0], char_code};
        end
        if (is_colon) begin
          colon_seen_next = 1'b1;
        end
      end else begin
        // Saturate the immediate once it passes the field
        if (accumulator_saturated || acc_sum[19:16] != 4'd0) begin
          number_accumulator_next    = 16'hFFFF;
          accumulator_saturated_next = 1'b1;
        end else begin
          number_accumulator_next = acc_sum[15:0];
        end
      end
    end else begin
      scan_mode_next = atl_pkg::MODE_IDLE;
      if (is_alpha || is_colon || is_digit) begin
        scan_mode_next             = is_digit ? atl_pkg::MODE_NUMBER : atl_pkg::MODE_WORD;
        run_start_next             = text_position;
        run_length_next            = RL_W'(1);
        leading_chars_next         = {24'd0, char_code};
        colon_seen_next            = is_colon;
        number_accumulator_next    = is_digit ? {12'd0, char_code[3:0]} : 16'd0;
        accumulator_saturated_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode             <= atl_pkg::MODE_IDLE;
      run_length            <= '0;
      leading_chars         <= '0;
      colon_seen            <= 1'b0;
      number_accumulator    <= '0;
      accumulator_saturated <= 1'b0;
      run_start             <= '0;
      text_position         <= '0;
    end else if (in_fire) begin
      scan_mode             <= scan_mode_next;
      run_length            <= run_length_next;
      leading_chars         <= leading_chars_next;
      colon_seen            <= colon_seen_next;
      number_accumulator    <= number_accumulator_next;
      accumulator_saturated <= accumulator_saturated_next;
      run_start             <= run_start_next;
      text_position         <= text_position_next;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + atl_pkg::QUEUE_AW'(push_n);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + atl_pkg::QUEUE_AW'(1);
      end
      count <= count + (in_fire ? atl_pkg::QUEUE_CW'(push_n) : '0)
                     - atl_pkg::QUEUE_CW'(out_fire);
    end
  end

  // Queue payload: write up to two tokens per beat
  always_ff @(posedge clk) begin
    if (in_fire && push_n != 2'd0) begin
      queue[wr_ptr] <= tok0;
    end
    if (in_fire && push_n == 2'd2) begin
      queue[wr_ptr + atl_pkg::QUEUE_AW'(1)] <= tok1;
    end
  end

  // Drive the head token
  assign token_kind      = queue[rd_ptr].kind;
  assign keyword_code    = queue[rd_ptr].code;
  assign number_value    = queue[rd_ptr].value;
  assign number_overflow = queue[rd_ptr].overflow;
  assign start_offset    = queue[rd_ptr].start;
  assign token_length    = queue[rd_ptr].length;
  assign last            = queue[rd_ptr].last;

endmodule

// File: sv/atl_checker.sv
// Port-level checker for the assembly token lexer, bound to the top level.
`timescale 1ns / 1ps

module atl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  char_code,
  input logic        end_of_text,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  token_kind,
  input logic [3:0]  keyword_code,
  input logic [15:0] number_value,
  input logic        number_overflow,
  input logic [15:0] start_offset,
  input logic [7:0]  token_length,
  input logic        last
);

  // No token straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token offered straight after reset");

  // A stalled token holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) &&
      $stable(start_offset) && $stable(token_length) && $stable(last))
    else $error("stalled token changed");

  // Comma and newline tokens are one character and carry no code
  a_punct_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == atl_pkg::KIND_COMMA || token_kind == atl_pkg::KIND_NEWLINE)
      |-> token_length == 8'd1 && keyword_code == 4'd0 && number_value == 16'd0)
    else $error("malformed comma or newline token");

  // Only immediates carry a value or overflow flag
  a_value_only_immed: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != atl_pkg::KIND_IMMED
      |-> number_value == 16'd0 && !number_overflow)
    else $error("value on a non-immediate token");

  // Overflow only with a saturated value
  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && number_overflow |-> number_value == 16'hFFFF)
    else $error("overflow without saturated value");

endmodule

bind assembly_token_lexer_top atl_checker u_atl_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the assembly token lexer: byte driver, token monitor, predictor.
`timescale 1ns / 1ps

module testbench;

  // One text beat as the driver presents it
  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_beat_t;

  // One token as the lexer reports it
  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  code;
    logic [15:0] value;
    logic        overflow;
    logic [15:0] origin;
    logic [7:0]  length;
    logic        last;
  } lex_token_t;

  localparam int unsigned LENGTH_CAP = 255;
  localparam int unsigned VALUE_CAP  = 65535;

  // Keyword tables, right-aligned like the packed word head
  localparam logic [31:0] MNEMONIC_TEXT [10] = '{
    "MOV", "ADD", "MVI", "AND", "ANI", "XOR", "SUB", "INR", "DCR", "JNZ"
  };
  localparam int unsigned MNEMONIC_CHARS [10] = '{3, 3, 3, 3, 3, 3, 3, 3, 3, 3};
  localparam logic [31:0] REGISTER_TEXT [10] = '{
    "A", "B", "C", "D", "E", "H", "L", "SP", "PC", "FLAG"
  };
  localparam int unsigned REGISTER_CHARS [10] = '{1, 1, 1, 1, 1, 1, 1, 2, 2, 4};

  // Space, tab, CR, VT and FF: skipped by the lexer
  localparam logic [7:0] BLANKS [5] = '{8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  token_kind;
  logic [3:0]  keyword_code;
  logic [15:0] number_value;
  logic        number_overflow;
  logic [15:0] start_offset;
  logic [7:0]  token_length;
  logic        last;

  assembly_token_lexer_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_code       (char_code),
    .end_of_text     (end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .token_kind      (token_kind),
    .keyword_code    (keyword_code),
    .number_value    (number_value),
    .number_overflow (number_overflow),
    .start_offset    (start_offset),
    .token_length    (token_length),
    .last            (last)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the scanner, reset values as after
  // the one reset at the start of the run.
  // ---------------------------------------------------------------------
  logic [1:0]  scan_state = atl_pkg::MODE_IDLE;
  int unsigned run_len    = 0;   // counts to LENGTH_CAP + 1 so matches stay exact
  logic [31:0] word_head  = '0;  // first four bytes of a word
  logic        has_colon  = 1'b0;
  int unsigned num_acc    = 0;
  logic        num_sat    = 1'b0;
  logic [15:0] run_origin = '0;
  logic [15:0] text_pos   = '0;  // wraps modulo 2^16 with OFFSET_BITS = 16

  lex_token_t  step_tokens[$];   // tokens of the beat being lexed
  lex_token_t  tokens_due[$];    // tokens predicted but not yet seen
  text_beat_t  beats_waiting[$]; // text not yet presented to the lexer
  text_beat_t  next_beat;

  int unsigned beats_planned = 0;
  int unsigned beats_sent    = 0;
  int unsigned tokens_seen   = 0;
  int unsigned faults        = 0;
  int unsigned kind_count [8];
  int unsigned overflow_count = 0;
  int unsigned capped_count   = 0;

  function automatic void emit(input logic [2:0] kind, input logic [3:0] code,
                               input logic [15:0] value, input logic overflow,
                               input logic [15:0] origin, input int unsigned len);
    lex_token_t t;
    t.kind     = kind;
    t.code     = code;
    t.value    = value;
    t.overflow = overflow;
    t.origin   = origin;
    t.length   = (len > LENGTH_CAP) ? 8'(LENGTH_CAP) : 8'(len);
    t.last     = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  // Close the pending word or number, if any, and fall back to idle
  function automatic void close_run();
    logic [2:0] kind;
    logic [3:0] code;
    kind = atl_pkg::KIND_UNKNOWN;
    code = '0;
    if (scan_state == atl_pkg::MODE_WORD) begin
      if (has_colon) begin
        kind = atl_pkg::KIND_LABEL;
      end else if (run_len <= 4) begin
        // mnemonics take priority over register names
        for (int i = 0; i < 10; i++) begin
          if (kind == atl_pkg::KIND_UNKNOWN && MNEMONIC_CHARS[i] == run_len &&
              MNEMONIC_TEXT[i] == word_head) begin
            kind = atl_pkg::KIND_INSTR;
            code = 4'(i);
          end
        end
        for (int i = 0; i < 10; i++) begin
          if (kind == atl_pkg::KIND_UNKNOWN && REGISTER_CHARS[i] == run_len &&
              REGISTER_TEXT[i] == word_head) begin
            kind = atl_pkg::KIND_REGISTER;
            code = 4'(i);
          end
        end
      end
      emit(kind, code, 16'd0, 1'b0, run_origin, run_len);
    end else if (scan_state == atl_pkg::MODE_NUMBER) begin
      emit(atl_pkg::KIND_IMMED, 4'd0, 16'(num_acc), num_sat, run_origin, run_len);
    end
    scan_state = atl_pkg::MODE_IDLE;
  endfunction

  function automatic void open_run(input logic [1:0] mode, input logic [7:0] ch);
    scan_state = mode;
    run_origin = text_pos;
    run_len    = 1;
    word_head  = {24'd0, ch};
    has_colon  = (ch == atl_pkg::CH_COLON);
    num_acc    = (mode == atl_pkg::MODE_NUMBER) ? 32'(ch - atl_pkg::CH_ZERO) : 0;
    num_sat    = 1'b0;
  endfunction

  // Lex one accepted beat and queue the tokens it gives
  function automatic void lex_byte(input logic [7:0] ch, input logic eot);
    logic        is_letter;
    logic        is_digit;
    logic        taken;
    int unsigned grown;
    is_letter = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
    is_digit  = (ch >= "0" && ch <= "9");
    taken     = 1'b0;
    step_tokens.delete();
    if (eot) begin
      // flush, and restart the offsets for the next text
      close_run();
      text_pos = '0;
    end else begin
      if (scan_state == atl_pkg::MODE_WORD) begin
        if (is_letter || is_digit || ch == atl_pkg::CH_COLON) begin
          if (run_len < 4) word_head = {word_head[23:0], ch};
          if (ch == atl_pkg::CH_COLON) has_colon = 1'b1;
          if (run_len < LENGTH_CAP + 1) run_len++;
          taken = 1'b1;
        end else begin
          close_run();
        end
      end else if (scan_state == atl_pkg::MODE_NUMBER) begin
        if (is_digit) begin
          grown = num_acc * 10 + (ch - atl_pkg::CH_ZERO);
          if (num_sat || grown > VALUE_CAP) begin
            grown   = VALUE_CAP;
            num_sat = 1'b1;
          end
          num_acc = grown;
          if (run_len < LENGTH_CAP + 1) run_len++;
          taken = 1'b1;
        end else begin
          close_run();
        end
      end
      // a byte that ended a run may still start one or give its own token
      if (!taken) begin
        if (is_letter || ch == atl_pkg::CH_COLON) begin
          open_run(atl_pkg::MODE_WORD, ch);
        end else if (is_digit) begin
          open_run(atl_pkg::MODE_NUMBER, ch);
        end else if (ch == atl_pkg::CH_COMMA) begin
          emit(atl_pkg::KIND_COMMA, 4'd0, 16'd0, 1'b0, text_pos, 1);
        end else if (ch == atl_pkg::CH_NEWLINE) begin
          emit(atl_pkg::KIND_NEWLINE, 4'd0, 16'd0, 1'b0, text_pos, 1);
        end
      end
      text_pos = text_pos + 16'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: present queued beats, hold each one while stalled, idle at
  // random except in a quiet stretch between beats 300 and 700.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        lex_byte(char_code, end_of_text);
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (beats_waiting.size() > 0 &&
            !($urandom_range(99) < 28 && !(beats_sent >= 300 && beats_sent < 700))) begin
          next_beat   = beats_waiting.pop_front();
          in_valid    <= 1'b1;
          char_code   <= next_beat.ch;
          end_of_text <= next_beat.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each token beat against the oldest prediction, stall at
  // random except between tokens 150 and 350.
  // ---------------------------------------------------------------------
  task automatic field_check(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      faults++;
      $display("%0t: token %0d %s expected %0d got %0d", $time, tokens_seen, field,
               want, got);
    end
  endtask

  lex_token_t want_token;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          faults++;
          $display("%0t: token %0d not expected: kind %0d offset %0d", $time,
                   tokens_seen, token_kind, start_offset);
        end else begin
          want_token = tokens_due.pop_front();
          field_check("token_kind", 16'(want_token.kind), 16'(token_kind));
          field_check("keyword_code", 16'(want_token.code), 16'(keyword_code));
          field_check("number_value", want_token.value, number_value);
          field_check("number_overflow", 16'(want_token.overflow), 16'(number_overflow));
          field_check("start_offset", want_token.origin, start_offset);
          field_check("token_length", 16'(want_token.length), 16'(token_length));
          field_check("last", 16'(want_token.last), 16'(last));
          kind_count[want_token.kind]++;
          if (want_token.overflow) overflow_count++;
          if (want_token.length == 8'(LENGTH_CAP)) capped_count++;
        end
        tokens_seen++;
      end
      out_stall <= ($urandom_range(99) < 28) && !(tokens_seen >= 150 && tokens_seen < 350);
    end
  end

  // ---------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    text_beat_t t;
    t.ch  = b;
    t.eot = 1'b0;
    beats_waiting.insert(beats_waiting.size(), t);
    beats_planned++;
  endtask

  // The byte under an end-of-text beat is random: it must be ignored
  task automatic push_eot();
    text_beat_t t;
    t.ch  = 8'($urandom);
    t.eot = 1'b1;
    beats_waiting.insert(beats_waiting.size(), t);
    beats_planned++;
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k]);
  endtask

  task automatic push_keyword(input logic [31:0] w, input int n);
    for (int k = n - 1; k >= 0; k--) push_byte(w[8*k +: 8]);
  endtask

  task automatic push_blank();
    repeat ($urandom_range(1, 2)) push_byte(BLANKS[$urandom_range(4)]);
  endtask

  function automatic logic [7:0] pick_letter();
    return 8'(($urandom_range(99) < 70 ? "A" : "a") + $urandom_range(25));
  endfunction

  // Random word; a label gets one colon at a random place, the start included
  task automatic push_word(input bit as_label);
    int unsigned len;
    int unsigned colon_at;
    len      = ($urandom_range(99) < 2) ? $urandom_range(200, 300) : $urandom_range(1, 8);
    colon_at = $urandom_range(len - 1);
    for (int unsigned k = 0; k < len; k++) begin
      if (as_label && k == colon_at) push_byte(atl_pkg::CH_COLON);
      else if (k == 0 || $urandom_range(3) != 0) push_byte(pick_letter());
      else push_byte(8'(atl_pkg::CH_ZERO + $urandom_range(9)));
    end
  endtask

  task automatic push_number();
    int unsigned len;
    len = ($urandom_range(99) < 3) ? $urandom_range(6, 25) : $urandom_range(1, 5);
    repeat (len) push_byte(8'(atl_pkg::CH_ZERO + $urandom_range(9)));
  endtask

  // Mostly well-formed source lines with random content, some noise
  task automatic push_line();
    int unsigned pick;
    int unsigned operands;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 10)) push_byte(8'($urandom));
    end else begin
      if ($urandom_range(99) < 15) begin
        push_word(1'b1);
        if ($urandom_range(1)) push_blank();
      end
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(9);
        push_keyword(MNEMONIC_TEXT[pick], MNEMONIC_CHARS[pick]);
        // near miss: keyword followed by more word characters
        if ($urandom_range(99) < 10) push_byte(pick_letter());
      end else begin
        push_word(1'b0);
      end
      operands = $urandom_range(2);
      for (int unsigned k = 0; k < operands; k++) begin
        if (k > 0) begin
          if ($urandom_range(3) == 0) push_blank();
          push_byte(atl_pkg::CH_COMMA);
        end
        if ($urandom_range(99) < 85) push_blank();
        pick = $urandom_range(99);
        if (pick < 50) begin
          pick = $urandom_range(9);
          push_keyword(REGISTER_TEXT[pick], REGISTER_CHARS[pick]);
        end else if (pick < 85) begin
          push_number();
          // digits straight into a word: the number ends, the word starts
          if ($urandom_range(99) < 20) push_word(1'b0);
        end else begin
          push_word(1'b0);
        end
      end
    end
    if ($urandom_range(99) < 85) push_byte(atl_pkg::CH_NEWLINE);
    else push_blank();
    if ($urandom_range(99) < 4) push_eot();
  endtask

  // Hold back new text until every beat is taken and every token is back
  task automatic wait_quiet();
    do @(negedge clk); while (beats_waiting.size() != 0 || in_valid);
    while (tokens_due.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: instruction, register, comma, newline, largest value,
    // label opened by a colon, overflow straight into a keyword, bytes
    // 0xFF and 0x00 skipped, end of text flushing a pending number.
    push_text("JNZ SP,65535\n");
    push_text(":L 65536FLAG");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_text("7");
    push_eot();
    wait_quiet();

    // Random text in two halves with a full drain in between
    random_start = beats_planned;
    while (beats_planned < random_start + 510) push_line();
    wait_quiet();
    while (beats_planned < random_start + 1020) push_line();
    push_eot();

    // Long runs: a word past the length cap, an overflowing number, then
    // a short word ended by a comma and a newline.
    push_eot();
    repeat (270) push_byte(pick_letter());
    push_byte(BLANKS[0]);
    push_text("123456789012345678901");
    push_text(" XYZ,\n");
    push_eot();

    wait_quiet();
    repeat (8) @(negedge clk);

    $display("covered %0d text beats, %0d tokens, %0d overflowed immediates, %0d capped",
             beats_sent, tokens_seen, overflow_count, capped_count);
    $display("kinds: unknown %0d instr %0d reg %0d imm %0d comma %0d newline %0d label %0d",
             kind_count[atl_pkg::KIND_UNKNOWN], kind_count[atl_pkg::KIND_INSTR],
             kind_count[atl_pkg::KIND_REGISTER], kind_count[atl_pkg::KIND_IMMED],
             kind_count[atl_pkg::KIND_COMMA], kind_count[atl_pkg::KIND_NEWLINE],
             kind_count[atl_pkg::KIND_LABEL]);
    if (faults == 0 && tokens_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d tokens still expected", tokens_due.size());
    $display("status: fail");
    $finish;
  end

endmodule
